[sv/mfpt_pkg.sv]
// Package: shared constants, beat structs and register codes for the position tracker.
`timescale 1ns / 1ps
package mfpt_pkg;

    localparam int NUM_MOTORS_DEF     = 8;
    localparam int ENCODER_COUNTS_DEF = 8192;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int STEP_LIMIT    = 4000;
    localparam int RATIO_FAST    = 19;
    localparam int RATIO_SLOW    = 36;
    localparam int DEG_PER_TURN  = 360;
    localparam int SPEED_DIV     = 19;

    localparam int ID_W      = 11;
    localparam int WORD_W    = 16;
    localparam int GEAR_W    = 8;
    localparam int MOTOR_W   = 4;
    localparam int IDXF_W    = 3;
    localparam int POS_W     = 48;
    localparam int SPD_W     = 28;
    localparam int MAG_W     = 16;
    localparam int STEP_W    = 18;
    localparam int MAGIC_W   = 64;
    localparam int HALF_W    = 32;
    localparam int PP_W      = MAG_W + HALF_W;
    localparam int PROD_W    = MAG_W + MAGIC_W;

    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 96;
    localparam int FRAME_W     = ID_W + 3 * WORD_W;
    localparam int RESULT_W    = IDXF_W + POS_W + SPD_W + WORD_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [ID_W-1:0]   BASE_ID_RESET     = 11'd513;
    localparam logic [GEAR_W-1:0] GEAR_SELECT_RESET = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_ID     = 2'd0,
        REG_GEAR_SELECT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]   base_id;
        logic [GEAR_W-1:0] gear_select;
    } cfg_t;

    // first member is the highest bits, so frame_id lands at bit 0
    typedef struct packed {
        logic signed [WORD_W-1:0] current_raw;
        logic signed [WORD_W-1:0] speed_raw;
        logic signed [WORD_W-1:0] angle_raw;
        logic [ID_W-1:0]          frame_id;
    } frame_t;

    typedef struct packed {
        logic [MOTOR_W-1:0]       idx;
        logic                     fast;
        logic                     neg;
        logic [MAG_W-1:0]         mag;
        logic                     spd_neg;
        logic [MAG_W-1:0]         spd_mag;
        logic signed [WORD_W-1:0] current;
    } step_t;

    typedef struct packed {
        logic [MOTOR_W-1:0]       idx;
        logic                     neg;
        logic [POS_W-1:0]         q;
        logic                     spd_neg;
        logic [SPD_W-1:0]         spd_q;
        logic signed [WORD_W-1:0] current;
    } delta_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] current_out;
        logic signed [SPD_W-1:0]  speed_scaled;
        logic signed [POS_W-1:0]  position_deg;
        logic [IDXF_W-1:0]        motor_index;
    } result_t;

endpackage

[sv/mfpt_unwrap.sv]
// Input register, motor lookup, angle state update and step unwrap stage.
`timescale 1ns / 1ps
module mfpt_unwrap #(
    parameter int NUM_MOTORS     = mfpt_pkg::NUM_MOTORS_DEF,
    parameter int ENCODER_COUNTS = mfpt_pkg::ENCODER_COUNTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mfpt_pkg::frame_t in_data,
    input  mfpt_pkg::cfg_t  cfg,
    output logic            out_valid,
    input  logic            out_ready,
    output mfpt_pkg::step_t out_data
);
    import mfpt_pkg::*;

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic signed [STEP_W-1:0] LIM_POS = STEP_W'(STEP_LIMIT);
    localparam logic signed [STEP_W-1:0] LIM_NEG = -STEP_W'(STEP_LIMIT);
    localparam logic signed [STEP_W-1:0] ENC_S   = STEP_W'(ENCODER_COUNTS);

    logic                     r0_valid_reg;
    frame_t                   r0_reg;
    logic                     r1_valid_reg;
    step_t                    r1_reg;
    logic signed [WORD_W-1:0] angle_prev_reg [NUM_MOTORS];
    logic signed [WORD_W-1:0] angle_now_reg  [NUM_MOTORS];

    logic                     r1_take;
    logic                     advance;
    logic [ID_W:0]            id_diff;
    logic                     hit;
    logic [IDX_W-1:0]         idx;
    logic [MOTOR_W-1:0]       idx_wide;
    logic signed [WORD_W-1:0] now_old;
    logic signed [WORD_W-1:0] prev_old;
    logic                     seed;
    logic signed [STEP_W-1:0] diff;
    logic signed [STEP_W-1:0] diff_u;
    logic [STEP_W-1:0]        abs_step;
    logic [WORD_W:0]          abs_spd;
    step_t                    step_next;

    assign r1_take  = !r1_valid_reg || out_ready;
    assign in_ready = !r0_valid_reg || r1_take;
    assign advance  = r0_valid_reg && r1_take;

    always_comb begin
        id_diff  = {1'b0, r0_reg.frame_id} - {1'b0, cfg.base_id};
        hit      = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(NUM_MOTORS));
        idx      = id_diff[IDX_W-1:0];
        idx_wide = MOTOR_W'(idx);
        now_old  = angle_now_reg[idx];
        prev_old = angle_prev_reg[idx];
        seed     = (now_old == '0) && (prev_old == '0);

        if (seed) begin
            diff = '0;
        end else begin
            diff = STEP_W'(r0_reg.angle_raw) - STEP_W'(now_old);
        end
        if (diff > LIM_POS) begin
            diff_u = diff - ENC_S;
        end else if (diff < LIM_NEG) begin
            diff_u = diff + ENC_S;
        end else begin
            diff_u = diff;
        end
        abs_step = diff_u[STEP_W-1] ? STEP_W'(-diff_u) : STEP_W'(diff_u);
        abs_spd  = r0_reg.speed_raw[WORD_W-1] ? (WORD_W+1)'(-(WORD_W+1)'(r0_reg.speed_raw))
                                              : (WORD_W+1)'(r0_reg.speed_raw);

        step_next.idx     = idx_wide;
        // motors past the gear register width run 36:1
        step_next.fast    = !idx_wide[MOTOR_W-1] && cfg.gear_select[idx_wide[IDXF_W-1:0]];
        step_next.neg     = diff_u[STEP_W-1];
        step_next.mag     = abs_step[MAG_W-1:0];
        step_next.spd_neg = r0_reg.speed_raw[WORD_W-1];
        step_next.spd_mag = abs_spd[MAG_W-1:0];
        step_next.current = r0_reg.current_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_valid_reg <= 1'b0;
            r1_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                angle_prev_reg[i] <= '0;
                angle_now_reg[i]  <= '0;
            end
        end else begin
            if (in_ready) begin
                r0_valid_reg <= in_valid;
            end
            if (r1_take) begin
                r1_valid_reg <= r0_valid_reg && hit;
            end
            if (advance && hit) begin
                angle_prev_reg[idx] <= seed ? r0_reg.angle_raw : now_old;
                angle_now_reg[idx]  <= r0_reg.angle_raw;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            r0_reg <= in_data;
        end
        if (advance) begin
            r1_reg <= step_next;
        end
    end

    assign out_valid = r1_valid_reg;
    assign out_data  = r1_reg;

`ifndef SYNTHESIS
    a_angle_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit) |=> angle_now_reg[$past(idx)] == $past(r0_reg.angle_raw))
        else $error("angle_now not updated for accepted frame");
    a_unknown_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !hit) |=> !r1_valid_reg)
        else $error("unknown identifier produced a beat");
    a_seed_zero_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit && seed) |=> (r1_reg.mag == '0))
        else $error("seeding frame produced a nonzero step");
`endif

endmodule

[sv/mfpt_scale.sv]
// Reciprocal-multiply stages: step to degrees and speed divided by 19, both Q.FRAC_BITS.
`timescale 1ns / 1ps
module mfpt_scale #(
    parameter int ENCODER_COUNTS = mfpt_pkg::ENCODER_COUNTS_DEF,
    parameter int FRAC_BITS      = mfpt_pkg::FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mfpt_pkg::step_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mfpt_pkg::delta_t out_data
);
    import mfpt_pkg::*;

    // floor(x*A/D) = (x*ceil(2^S*A/D)) >> S for x < 2^MAG_W when 2^S >= 2^MAG_W*D
    localparam int D_FAST = RATIO_FAST * ENCODER_COUNTS;
    localparam int D_SLOW = RATIO_SLOW * ENCODER_COUNTS;
    localparam int S_POS  = MAG_W + $clog2(D_SLOW) + 1;
    localparam int S_SPD  = MAG_W + $clog2(SPEED_DIV) + 1;
    localparam logic [127:0] NUM_POS = 128'(DEG_PER_TURN) << (FRAC_BITS + S_POS);
    localparam logic [127:0] NUM_SPD = 128'(1) << (FRAC_BITS + S_SPD);
    localparam logic [MAGIC_W-1:0] MAGIC_FAST =
        MAGIC_W'((NUM_POS + 128'(D_FAST - 1)) / 128'(D_FAST));
    localparam logic [MAGIC_W-1:0] MAGIC_SLOW =
        MAGIC_W'((NUM_POS + 128'(D_SLOW - 1)) / 128'(D_SLOW));
    localparam logic [MAGIC_W-1:0] MAGIC_SPD =
        MAGIC_W'((NUM_SPD + 128'(SPEED_DIV - 1)) / 128'(SPEED_DIV));

    typedef struct packed {
        logic [MOTOR_W-1:0]       idx;
        logic                     neg;
        logic [PP_W-1:0]          pos_lo;
        logic [PP_W-1:0]          pos_hi;
        logic                     spd_neg;
        logic [PP_W-1:0]          spd_lo;
        logic [PP_W-1:0]          spd_hi;
        logic signed [WORD_W-1:0] current;
    } prod_t;

    logic               b_valid_reg;
    prod_t              b_reg;
    logic               c_valid_reg;
    delta_t             c_reg;

    logic               c_take;
    logic [MAGIC_W-1:0] magic;
    prod_t              b_next;
    logic [PROD_W-1:0]  pos_prod;
    logic [PROD_W-1:0]  spd_prod;
    delta_t             c_next;

    assign c_take   = !c_valid_reg || out_ready;
    assign in_ready = !b_valid_reg || c_take;

    always_comb begin
        magic          = in_data.fast ? MAGIC_FAST : MAGIC_SLOW;
        b_next.idx     = in_data.idx;
        b_next.neg     = in_data.neg;
        b_next.pos_lo  = PP_W'(in_data.mag * magic[HALF_W-1:0]);
        b_next.pos_hi  = PP_W'(in_data.mag * magic[MAGIC_W-1:HALF_W]);
        b_next.spd_neg = in_data.spd_neg;
        b_next.spd_lo  = PP_W'(in_data.spd_mag * MAGIC_SPD[HALF_W-1:0]);
        b_next.spd_hi  = PP_W'(in_data.spd_mag * MAGIC_SPD[MAGIC_W-1:HALF_W]);
        b_next.current = in_data.current;
    end

    always_comb begin
        pos_prod       = PROD_W'(b_reg.pos_lo) + (PROD_W'(b_reg.pos_hi) << HALF_W);
        spd_prod       = PROD_W'(b_reg.spd_lo) + (PROD_W'(b_reg.spd_hi) << HALF_W);
        c_next.idx     = b_reg.idx;
        c_next.neg     = b_reg.neg;
        c_next.q       = POS_W'(pos_prod >> S_POS);
        c_next.spd_neg = b_reg.spd_neg;
        c_next.spd_q   = SPD_W'(spd_prod >> S_SPD);
        c_next.current = b_reg.current;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                b_valid_reg <= in_valid;
            end
            if (c_take) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            b_reg <= b_next;
        end
        if (c_take && b_valid_reg) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_reg;

endmodule

[sv/mfpt_accum.sv]
// Per-motor position accumulator, sign restore and result register.
`timescale 1ns / 1ps
module mfpt_accum #(
    parameter int NUM_MOTORS = mfpt_pkg::NUM_MOTORS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mfpt_pkg::delta_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mfpt_pkg::result_t out_data
);
    import mfpt_pkg::*;

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    logic [POS_W-1:0] pos_acc_reg [NUM_MOTORS];
    logic             out_valid_reg;
    result_t          out_reg;

    logic             load;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] acc_old;
    logic [POS_W-1:0] acc_next;
    logic [SPD_W-1:0] spd_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        idx      = in_data.idx[IDX_W-1:0];
        acc_old  = pos_acc_reg[idx];
        acc_next = in_data.neg ? acc_old - in_data.q : acc_old + in_data.q;
        spd_next = in_data.spd_neg ? SPD_W'(-in_data.spd_q) : in_data.spd_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                pos_acc_reg[i] <= '0;
            end
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (load) begin
                pos_acc_reg[idx] <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg.motor_index  <= IDXF_W'(in_data.idx);
            out_reg.position_deg <= acc_next;
            out_reg.speed_scaled <= spd_next;
            out_reg.current_out  <= in_data.current;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_pos_matches_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> out_reg.position_deg == pos_acc_reg[$past(idx)])
        else $error("result position differs from stored accumulator");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("result beat changed while stalled");
    a_idle_acc_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !in_ready) |=> pos_acc_reg[$past(idx)] == $past(acc_old))
        else $error("accumulator changed without a beat");
`endif

endmodule

[sv/motor_feedback_position_tracker_core.sv]
// Top level: motor feedback position tracker, stream ports and configuration registers.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: frame beat
//  m_       out  m_tvalid/m_tready    m_tdata: result beat
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Five register stages: input, unwrap, partial products, sum, accumulate/result.
// One beat per cycle while m_tready stays high; a result is on m_tdata once its frame has passed every register stage.
// The partial-product split of the 16x64 reciprocal multiply sets the stage count.
// Reset clears stage valids, all angle and position state, base_id to 513, gear_select to 3.
// m_tready low stalls stage by stage; s_tready drops only when every stage is full.
`timescale 1ns / 1ps
module motor_feedback_position_tracker_core #(
    parameter int NUM_MOTORS     = mfpt_pkg::NUM_MOTORS_DEF,
    parameter int ENCODER_COUNTS = mfpt_pkg::ENCODER_COUNTS_DEF,
    parameter int FRAC_BITS      = mfpt_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_id[10:0], angle_raw[26:11], speed_raw[42:27], current_raw[58:43], zero[63:59]
    input  logic [mfpt_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // motor_index[2:0], position_deg[50:3], speed_scaled[78:51], current_out[94:79], zero[95]
    output logic [mfpt_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mfpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mfpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfpt_pkg::*;

    cfg_t    cfg_reg;
    frame_t  frame;
    logic    u_valid;
    logic    u_ready;
    step_t   u_data;
    logic    c_valid;
    logic    c_ready;
    delta_t  c_data;
    result_t res;

    assign cfg_ready = 1'b1;
    assign frame     = s_tdata[FRAME_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_id     <= BASE_ID_RESET;
            cfg_reg.gear_select <= GEAR_SELECT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BASE_ID:     cfg_reg.base_id     <= cfg_data[ID_W-1:0];
                REG_GEAR_SELECT: cfg_reg.gear_select <= cfg_data[GEAR_W-1:0];
                default: ;
            endcase
        end
    end

    mfpt_unwrap #(
        .NUM_MOTORS     (NUM_MOTORS),
        .ENCODER_COUNTS (ENCODER_COUNTS)
    ) u_unwrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (frame),
        .cfg       (cfg_reg),
        .out_valid (u_valid),
        .out_ready (u_ready),
        .out_data  (u_data)
    );

    mfpt_scale #(
        .ENCODER_COUNTS (ENCODER_COUNTS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (u_valid),
        .in_ready  (u_ready),
        .in_data   (u_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    mfpt_accum #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {(M_TDATA_W - RESULT_W)'(0), res};

endmodule

[dv/motor_feedback_position_tracker_core_tb.sv]
// Testbench: position tracker frames against a cycle-free predictor, with random bus pressure.
`timescale 1ns / 1ps
module motor_feedback_position_tracker_core_tb;
    import mfpt_pkg::*;

    localparam int NUM_MOTORS = NUM_MOTORS_DEF;
    localparam int PIPE_LAT   = 5;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    motor_feedback_position_tracker_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // tracker copy: angles, positions and registers
    logic signed [WORD_W-1:0] trk_angle_prev [NUM_MOTORS];
    logic signed [WORD_W-1:0] trk_angle_now  [NUM_MOTORS];
    logic [POS_W-1:0]         trk_position   [NUM_MOTORS];
    logic [ID_W-1:0]          trk_base_id;
    logic [GEAR_W-1:0]        trk_gear;

    result_t     pending_results[$];
    int unsigned mismatches     = 0;
    int          src_gap_pct    = 0;
    int          sink_stall_pct = 0;

    function automatic longint trunc_scale(longint x, longint unsigned mul,
                                           longint unsigned den);
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        neg = x < 0;
        mag = neg ? longint'(-x) : longint'(x);
        q   = ((mag * mul) << FRAC_BITS_DEF) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // updates the tracker copy; returns 0 for an identifier outside the motor window
    function automatic bit track_frame(frame_t f, output result_t r);
        int unsigned     slot;
        int              step;
        longint unsigned ratio;
        longint          delta;
        longint          spd;
        r = '0;
        if (f.frame_id < trk_base_id) return 1'b0;
        slot = f.frame_id - trk_base_id;
        if (slot >= NUM_MOTORS) return 1'b0;
        if (trk_angle_prev[slot] == 0 && trk_angle_now[slot] == 0) begin
            trk_angle_prev[slot] = f.angle_raw;
            trk_angle_now[slot]  = f.angle_raw;
        end else begin
            trk_angle_prev[slot] = trk_angle_now[slot];
            trk_angle_now[slot]  = f.angle_raw;
        end
        step = int'($signed(trk_angle_now[slot])) - int'($signed(trk_angle_prev[slot]));
        if (step > STEP_LIMIT)
            step -= ENCODER_COUNTS_DEF;
        else if (step < -STEP_LIMIT)
            step += ENCODER_COUNTS_DEF;
        ratio = trk_gear[slot] ? RATIO_FAST : RATIO_SLOW;
        delta = trunc_scale(step, DEG_PER_TURN, ratio * ENCODER_COUNTS_DEF);
        trk_position[slot] = trk_position[slot] + delta[POS_W-1:0];
        spd = trunc_scale(longint'($signed(f.speed_raw)), 1, SPEED_DIV);
        r.motor_index  = slot[IDXF_W-1:0];
        r.position_deg = trk_position[slot];
        r.speed_scaled = spd[SPD_W-1:0];
        r.current_out  = f.current_raw;
        return 1'b1;
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_W-1:0];
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: motor_index %0d", got.motor_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.motor_index !== want.motor_index) begin
                    $error("motor_index mismatch: expected %0d, got %0d",
                           want.motor_index, got.motor_index);
                    mismatches++;
                end
                if (got.position_deg !== want.position_deg) begin
                    $error("position_deg mismatch: expected %0d, got %0d",
                           $signed(want.position_deg), $signed(got.position_deg));
                    mismatches++;
                end
                if (got.speed_scaled !== want.speed_scaled) begin
                    $error("speed_scaled mismatch: expected %0d, got %0d",
                           $signed(want.speed_scaled), $signed(got.speed_scaled));
                    mismatches++;
                end
                if (got.current_out !== want.current_out) begin
                    $error("current_out mismatch: expected %0d, got %0d",
                           $signed(want.current_out), $signed(got.current_out));
                    mismatches++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge with s_tvalid still high
    task automatic send_frame(input logic [ID_W-1:0] id, input int angle, input int speed,
                              input int current, output bit hit);
        frame_t  f;
        result_t r;
        f.frame_id    = id;
        f.angle_raw   = angle[WORD_W-1:0];
        f.speed_raw   = speed[WORD_W-1:0];
        f.current_raw = current[WORD_W-1:0];
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-FRAME_W){1'b0}}, f};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hit = track_frame(f, r);
        if (hit) pending_results.push_back(r);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        // frames with unknown IDs may still be in flight
        repeat (PIPE_LAT + 3) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_BASE_ID)
            trk_base_id = value[ID_W-1:0];
        else
            trk_gear = value[GEAR_W-1:0];
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [ID_W-1:0] base, input logic [GEAR_W-1:0] gear);
        drain_results();
        write_reg(REG_BASE_ID, base);
        write_reg(REG_GEAR_SELECT, CFG_DATA_W'(gear));
        cfg_valid <= 1'b0;
    endtask

    // motor 0 (19:1) under reset registers: seeding, unwrap thresholds, speed/current extremes
    task automatic test_seed_and_unwrap();
        bit hit;
        send_frame(11'd513, 0,    32767,  32767,  hit);
        send_frame(11'd513, 100,  -32768, -32768, hit);
        send_frame(11'd513, 4100, 0,      0,      hit);
        send_frame(11'd513, 100,  -1,     -1,     hit);
        send_frame(11'd513, 4101, 1,      1,      hit);
        send_frame(11'd513, 100,  19,     -19,    hit);
        send_frame(11'd513, 0,    -19,    12345,  hit);
        send_frame(11'd513, 0,    18,     -12345, hit);
        send_frame(11'd513, 7,    -18,    0,      hit);
    endtask

    // motor 7 (36:1): full-range angle swings and reseeding at zero
    task automatic test_angle_extremes();
        bit hit;
        send_frame(11'd520, 32767,  21845,  1,     hit);
        send_frame(11'd520, -32768, -21846, 2,     hit);
        send_frame(11'd520, 32767,  100,    3,     hit);
        send_frame(11'd520, 0,      -100,   4,     hit);
        send_frame(11'd520, 0,      5000,   5,     hit);
        send_frame(11'd520, 5,      -5000,  6,     hit);
    endtask

    task automatic test_unknown_ids();
        bit hit;
        send_frame(11'd512,  1234, 77,  88,  hit);
        send_frame(11'd521,  1234, 77,  88,  hit);
        send_frame(11'd0,    1234, 77,  88,  hit);
        send_frame(11'd2047, 1234, 77,  88,  hit);
        send_frame(11'd1024, 1234, 77,  88,  hit);
        send_frame(11'd514,  -300, -77, -88, hit);
    endtask

    task automatic test_random_traffic(input int n_frames, input int gap, input int stall,
                                       input logic [ID_W-1:0] base,
                                       input logic [GEAR_W-1:0] gear);
        int          known;
        int          span;
        int          k;
        int          roll;
        int          prev;
        int          angle;
        logic [ID_W-1:0] id;
        bit          hit;
        known = 0;
        apply_config(base, gear);
        src_gap_pct    = gap;
        sink_stall_pct = stall;
        span = (2047 - int'(base) < 7) ? 2047 - int'(base) : 7;
        while (known < n_frames) begin
            k    = $urandom_range(span);
            roll = $urandom_range(99);
            if (roll < 8)
                id = ID_W'($urandom_range(2047));
            else if (roll < 12 && base != 0)
                id = base - ID_W'(1);
            else if (roll < 15 && int'(base) + 8 <= 2047)
                id = base + ID_W'(8);
            else
                id = base + ID_W'(k);
            prev = int'($signed(trk_angle_now[k]));
            roll = $urandom_range(99);
            if (roll < 50)
                angle = prev + int'($urandom_range(600)) - 300;
            else if (roll < 68)
                angle = prev + ($urandom_range(1) ? 1 : -1) * (3995 + int'($urandom_range(10)));
            else if (roll < 80)
                angle = prev + ($urandom_range(1) ? 1 : -1) * (8192 - int'($urandom_range(300)));
            else if (roll < 88)
                angle = 0;
            else
                angle = $urandom_range(65535);
            send_frame(id, angle, $urandom_range(65535), $urandom_range(65535), hit);
            if (hit) known++;
        end
        src_gap_pct    = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
            trk_angle_prev[i] = '0;
            trk_angle_now[i]  = '0;
            trk_position[i]   = '0;
        end
        trk_base_id = BASE_ID_RESET;
        trk_gear    = GEAR_SELECT_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_seed_and_unwrap();
        test_angle_extremes();
        test_unknown_ids();
        test_random_traffic(500, 0,  0,  11'd0,    8'h00);
        test_random_traffic(200, 62, 0,  11'd2047, 8'hFF);
        test_random_traffic(500, 0,  62, 11'd2040, 8'hA5);
        test_random_traffic(500, 21, 21, ID_W'($urandom_range(2047)),
                            GEAR_W'($urandom_range(255)));
        test_random_traffic(300, 0,  0,  11'd513,  GEAR_W'($urandom_range(255)));

        drain_results();
        repeat (PIPE_LAT + 10) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/mfpt_pkg.sv
sv/mfpt_unwrap.sv
sv/mfpt_scale.sv
sv/mfpt_accum.sv
sv/motor_feedback_position_tracker_core.sv
dv/motor_feedback_position_tracker_core_tb.sv
